// File: rtl/assert_macros.svh
// Assertion helpers shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define RRTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");

// Next-cycle implication, off while reset is asserted.
`define RRTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");

`endif

// File: rtl/rrts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and codes for the round-robin task scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

  // Event kinds carried on the input tuser
  typedef enum logic [2:0] {
    K_ADD     = 3'd0,
    K_BLOCK   = 3'd1,
    K_UNBLOCK = 3'd2,
    K_SCHED   = 3'd3,
    K_YIELD   = 3'd4,
    K_START   = 3'd5
  } kind_t;

  // Per-slot task state
  typedef enum logic [1:0] {
    ST_ABSENT  = 2'd0,
    ST_READY   = 2'd1,
    ST_BLOCKED = 2'd2,
    ST_RUNNING = 2'd3
  } slot_st_t;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ID_WR,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_APPEND,
    S_PICK,
    S_OLD,
    S_NEW,
    S_HEAD,
    S_HEAD_CHK,
    S_OUT
  } fsm_t;

  // Address source for the slot table port
  typedef enum logic [1:0] {
    RS_ID,
    RS_SCAN,
    RS_TARGET,
    RS_CUR
  } rsel_t;

  typedef struct packed {
    rsel_t rsel;
    logic  capture;
    logic  id_write;
    logic  scan_chk;
    logic  append;
    logic  swap_old;
    logic  swap_new;
    logic  take_head;
    logic  load_out;
  } cmd_t;

  typedef struct packed {
    kind_t    kind;
    logic     id_ok;
    slot_st_t st_rd;
    logic     len_zero;
    logic     idx_last;
    logic     target_valid;
    logic     target_is_cur;
    logic     present;
  } sts_t;

  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned ID_W       = 4;
  localparam int unsigned ID_SLOTS   = 16;

endpackage

// File: rtl/round_robin_task_scheduler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_task_scheduler_top
// Round-robin task scheduler: slot table plus ordered ready list.
// ----------------------------------------------------------------------------
// Each input beat is one event (add, block, unblock, schedule, yield, start)
// and yields exactly one output beat reporting the current task afterwards.
// Events are processed one at a time. Add and unblock walk the ready list,
// as do schedule and yield; the ready list holds at most 16 slots. The walk
// reads the order-list RAM: each entry is read by presenting its address in
// S_SCAN_RD and then using the registered read data in S_SCAN_CHK. A new
// event is taken as soon as the previous one has reached the output register,
// even if that beat is still stalled. No clearing pass is needed after reset;
// the list RAM is only read within the valid length.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler_top #(
  // Slot table size; only slots 0..15 can be named by a task id
  parameter int unsigned MAX_TASKS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Event channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [rrts_pkg::IN_DATA_W-1:0]      in_tdata,   // [3:0] task_id, [4] user_mode
  input  logic [rrts_pkg::IN_USER_W-1:0]      in_tuser,   // [2:0] kind
  // Result channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [rrts_pkg::OUT_DATA_W-1:0]     out_tdata   // [0] acted, [1] switched,
                                                          // [2] running_valid,
                                                          // [6:3] running_id,
                                                          // [7] running_user,
                                                          // [8] previous_valid,
                                                          // [12:9] previous_id
);

  rrts_pkg::cmd_t cmd;
  rrts_pkg::sts_t sts;

  // Sequencer: decode, list walk, task switch, result hand-off
  rrts_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Slot table, ready list, current task and result register
  rrts_dpath #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata)
  );

endmodule

// File: rtl/rrts_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rrts_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/rrts_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// rrts_ctrl
// Event sequencer: steps the datapath through decode, list scan and update.
// ----------------------------------------------------------------------------
module rrts_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  rrts_pkg::sts_t sts,
  output rrts_pkg::cmd_t cmd
);

  rrts_pkg::fsm_t state_r, state_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_free;
  logic           start_needed;

  assign out_free     = !out_valid_r || out_tready;
  assign start_needed = !sts.present || !sts.target_is_cur ||
                        (sts.st_rd != rrts_pkg::ST_RUNNING);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rrts_pkg::S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = rrts_pkg::S_DECODE;
        end
      end
      rrts_pkg::S_DECODE: begin
        case (sts.kind)
          rrts_pkg::K_ADD: begin
            state_nxt = sts.id_ok ? rrts_pkg::S_ID_WR : rrts_pkg::S_OUT;
          end
          rrts_pkg::K_BLOCK: begin
            state_nxt = (sts.id_ok && sts.st_rd != rrts_pkg::ST_ABSENT &&
                         sts.st_rd != rrts_pkg::ST_BLOCKED) ?
                        rrts_pkg::S_ID_WR : rrts_pkg::S_OUT;
          end
          rrts_pkg::K_UNBLOCK: begin
            state_nxt = (sts.id_ok && sts.st_rd == rrts_pkg::ST_BLOCKED) ?
                        rrts_pkg::S_ID_WR : rrts_pkg::S_OUT;
          end
          rrts_pkg::K_SCHED: begin
            state_nxt = sts.len_zero ? rrts_pkg::S_OUT : rrts_pkg::S_SCAN_RD;
          end
          rrts_pkg::K_YIELD: begin
            state_nxt = (sts.len_zero || !sts.present) ?
                        rrts_pkg::S_OUT : rrts_pkg::S_SCAN_RD;
          end
          rrts_pkg::K_START: begin
            state_nxt = sts.len_zero ? rrts_pkg::S_OUT : rrts_pkg::S_HEAD;
          end
          default: begin
            state_nxt = rrts_pkg::S_OUT;
          end
        endcase
      end
      rrts_pkg::S_ID_WR: begin
        if (sts.kind == rrts_pkg::K_BLOCK) begin
          state_nxt = rrts_pkg::S_OUT;
        end else if (sts.len_zero) begin
          state_nxt = rrts_pkg::S_APPEND;
        end else begin
          state_nxt = rrts_pkg::S_SCAN_RD;
        end
      end
      rrts_pkg::S_SCAN_RD: begin
        state_nxt = rrts_pkg::S_SCAN_CHK;
      end
      rrts_pkg::S_SCAN_CHK: begin
        if (!sts.idx_last) begin
          state_nxt = rrts_pkg::S_SCAN_RD;
        end else if (sts.kind == rrts_pkg::K_ADD || sts.kind == rrts_pkg::K_UNBLOCK) begin
          state_nxt = rrts_pkg::S_APPEND;
        end else begin
          state_nxt = rrts_pkg::S_PICK;
        end
      end
      rrts_pkg::S_APPEND: begin
        state_nxt = rrts_pkg::S_OUT;
      end
      rrts_pkg::S_PICK: begin
        if (!sts.target_valid || sts.target_is_cur) begin
          state_nxt = rrts_pkg::S_OUT;
        end else begin
          state_nxt = sts.present ? rrts_pkg::S_OLD : rrts_pkg::S_NEW;
        end
      end
      rrts_pkg::S_OLD: begin
        state_nxt = rrts_pkg::S_NEW;
      end
      rrts_pkg::S_NEW: begin
        state_nxt = rrts_pkg::S_OUT;
      end
      rrts_pkg::S_HEAD: begin
        state_nxt = rrts_pkg::S_HEAD_CHK;
      end
      rrts_pkg::S_HEAD_CHK: begin
        if (!start_needed) begin
          state_nxt = rrts_pkg::S_OUT;
        end else begin
          state_nxt = sts.present ? rrts_pkg::S_OLD : rrts_pkg::S_NEW;
        end
      end
      rrts_pkg::S_OUT: begin
        if (out_free) begin
          state_nxt = rrts_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = rrts_pkg::S_IDLE;
      end
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    cmd.rsel = rrts_pkg::RS_ID;
    case (state_r)
      rrts_pkg::S_IDLE: begin
        cmd.capture = in_tvalid;
      end
      rrts_pkg::S_ID_WR: begin
        cmd.id_write = 1'b1;
      end
      rrts_pkg::S_SCAN_CHK: begin
        cmd.rsel     = rrts_pkg::RS_SCAN;
        cmd.scan_chk = 1'b1;
      end
      rrts_pkg::S_APPEND: begin
        cmd.append = 1'b1;
      end
      rrts_pkg::S_PICK: begin
        cmd.rsel = rrts_pkg::RS_TARGET;
      end
      rrts_pkg::S_OLD: begin
        cmd.rsel     = rrts_pkg::RS_CUR;
        cmd.swap_old = 1'b1;
      end
      rrts_pkg::S_NEW: begin
        cmd.rsel     = rrts_pkg::RS_TARGET;
        cmd.swap_new = 1'b1;
      end
      rrts_pkg::S_HEAD: begin
        cmd.take_head = 1'b1;
      end
      rrts_pkg::S_HEAD_CHK: begin
        cmd.rsel = rrts_pkg::RS_TARGET;
      end
      rrts_pkg::S_OUT: begin
        cmd.load_out = out_free;
      end
      default: begin
        cmd.rsel = rrts_pkg::RS_ID;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rrts_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == rrts_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;

  `RRTS_ASSERT_NXT(a_accept_decodes, clk, rst_n, in_tvalid && in_tready, state_r == rrts_pkg::S_DECODE)
  `RRTS_ASSERT_IMP(a_switch_has_target, clk, rst_n, state_r == rrts_pkg::S_NEW, sts.target_valid)
  `RRTS_ASSERT_NXT(a_load_shows_beat, clk, rst_n, cmd.load_out, out_valid_r && state_r == rrts_pkg::S_IDLE)

endmodule

// File: rtl/rrts_dpath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// rrts_dpath
// Slot table, ready list RAM, current task and result register.
// ----------------------------------------------------------------------------
module rrts_dpath #(
  parameter int unsigned MAX_TASKS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [rrts_pkg::IN_DATA_W-1:0]       in_tdata,
  input  logic [rrts_pkg::IN_USER_W-1:0]       in_tuser,
  input  rrts_pkg::cmd_t                       cmd,
  output rrts_pkg::sts_t                       sts,
  output logic [rrts_pkg::OUT_DATA_W-1:0]      out_tdata
);

  // Only slots that a 4-bit task id can name are ever touched
  localparam int unsigned NSLOT = (MAX_TASKS < rrts_pkg::ID_SLOTS) ?
                                  MAX_TASKS : rrts_pkg::ID_SLOTS;
  localparam int unsigned SW = $clog2(NSLOT);
  localparam int unsigned LW = $clog2(NSLOT + 1);

  // Event registers
  logic [rrts_pkg::IN_USER_W-1:0] kind_r;
  logic [rrts_pkg::ID_W-1:0]      id_r;
  logic                           user_r;

  // Scheduler state
  rrts_pkg::slot_st_t st_r  [NSLOT];
  logic               usr_r [NSLOT];
  logic [LW-1:0]      len_r;
  logic [SW-1:0]      cur_r;
  logic               present_r;
  logic               cur_user_r;

  // Scan state
  logic [LW-1:0] idx_r;
  logic          found_r;
  logic          curhit_r;
  logic          after_v_r;
  logic [SW-1:0] after_r;
  logic          first_v_r;
  logic [SW-1:0] first_r;

  // Result flags
  logic          acted_r;
  logic          switched_r;
  logic          prev_valid_r;
  logic [SW-1:0] prev_id_r;
  logic [rrts_pkg::OUT_DATA_W-1:0] out_data_r;

  logic               is_move;
  logic               id_ok;
  logic [SW-1:0]      id_slot;
  logic [SW-1:0]      target;
  logic [SW-1:0]      addr;
  rrts_pkg::slot_st_t st_rd;
  logic               usr_rd;
  logic [LW:0]        idx_inc;

  logic          ram_we;
  logic [SW-1:0] ram_waddr;
  logic [SW-1:0] ram_wdata;
  logic [SW-1:0] ram_rdata;
  logic [LW-1:0] tail;

  assign is_move = (kind_r == rrts_pkg::K_ADD) || (kind_r == rrts_pkg::K_UNBLOCK);
  assign id_ok   = (32'(id_r) < 32'(NSLOT));
  assign id_slot = id_r[SW-1:0];
  assign target  = after_v_r ? after_r : first_r;
  assign idx_inc = {1'b0, idx_r} + (LW + 1)'(1);
  assign tail    = found_r ? (len_r - LW'(1)) : len_r;

  // One table port: every read and write goes through this address
  always_comb begin
    case (cmd.rsel)
      rrts_pkg::RS_ID:     addr = id_slot;
      rrts_pkg::RS_SCAN:   addr = ram_rdata;
      rrts_pkg::RS_TARGET: addr = target;
      rrts_pkg::RS_CUR:    addr = cur_r;
      default:             addr = id_slot;
    endcase
  end

  assign st_rd  = st_r[addr];
  assign usr_rd = usr_r[addr];

  // Ready list: shift entries down behind the moved slot, then write the tail
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tail[SW-1:0];
    ram_wdata = id_slot;
    if (cmd.append) begin
      ram_we = 1'b1;
    end else if (cmd.scan_chk && is_move && found_r) begin
      ram_we    = 1'b1;
      ram_waddr = SW'(idx_r - LW'(1));
      ram_wdata = ram_rdata;
    end
  end

  rrts_ram #(
    .WIDTH (SW),
    .DEPTH (NSLOT)
  ) u_list (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r[SW-1:0]),
    .rdata (ram_rdata)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < int'(NSLOT); i++) begin
        st_r[i]  <= rrts_pkg::ST_ABSENT;
        usr_r[i] <= 1'b0;
      end
      len_r      <= '0;
      cur_r      <= '0;
      present_r  <= 1'b0;
      cur_user_r <= 1'b0;
    end else begin
      if (cmd.id_write) begin
        st_r[addr] <= (kind_r == rrts_pkg::K_BLOCK) ?
                      rrts_pkg::ST_BLOCKED : rrts_pkg::ST_READY;
        if (kind_r == rrts_pkg::K_ADD) begin
          usr_r[addr] <= user_r;
          if (present_r && cur_r == addr) begin
            cur_user_r <= user_r;
          end
        end
      end
      if (cmd.append && !found_r) begin
        len_r <= len_r + LW'(1);
      end
      // Previous task drops back to ready only on schedule or yield
      if (cmd.swap_old && kind_r != rrts_pkg::K_START && st_rd == rrts_pkg::ST_RUNNING) begin
        st_r[addr] <= rrts_pkg::ST_READY;
      end
      if (cmd.swap_new) begin
        st_r[addr] <= rrts_pkg::ST_RUNNING;
        cur_r      <= addr;
        present_r  <= 1'b1;
        cur_user_r <= usr_rd;
      end
    end
  end

  // Per-event working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r       <= in_tuser;
      id_r         <= in_tdata[rrts_pkg::ID_W-1:0];
      user_r       <= in_tdata[rrts_pkg::ID_W];
      idx_r        <= '0;
      found_r      <= 1'b0;
      curhit_r     <= 1'b0;
      after_v_r    <= 1'b0;
      first_v_r    <= 1'b0;
      acted_r      <= 1'b0;
      switched_r   <= 1'b0;
      prev_valid_r <= 1'b0;
      prev_id_r    <= '0;
    end
    if (cmd.scan_chk) begin
      idx_r <= idx_inc[LW-1:0];
      if (is_move) begin
        if (ram_rdata == id_slot) begin
          found_r <= 1'b1;
        end
      end else begin
        if (present_r && ram_rdata == cur_r) begin
          curhit_r <= 1'b1;
        end
        if (st_rd == rrts_pkg::ST_READY) begin
          if (!first_v_r) begin
            first_v_r <= 1'b1;
            first_r   <= ram_rdata;
          end
          // first ready slot past the current one wins over a wrapped match
          if (curhit_r && !after_v_r) begin
            after_v_r <= 1'b1;
            after_r   <= ram_rdata;
          end
        end
      end
    end
    if (cmd.take_head) begin
      first_v_r <= 1'b1;
      first_r   <= ram_rdata;
    end
    if (cmd.id_write || cmd.append) begin
      acted_r <= 1'b1;
    end
    if (cmd.swap_old) begin
      prev_valid_r <= 1'b1;
      prev_id_r    <= cur_r;
    end
    if (cmd.swap_new) begin
      acted_r    <= 1'b1;
      switched_r <= 1'b1;
    end
    if (cmd.load_out) begin
      out_data_r <= {3'b000,
                     rrts_pkg::ID_W'(prev_id_r),
                     prev_valid_r,
                     present_r & cur_user_r,
                     present_r ? rrts_pkg::ID_W'(cur_r) : rrts_pkg::ID_W'(0),
                     present_r,
                     switched_r,
                     acted_r};
    end
  end

  assign out_tdata = out_data_r;

  assign sts.kind          = rrts_pkg::kind_t'(kind_r);
  assign sts.id_ok         = id_ok;
  assign sts.st_rd         = st_rd;
  assign sts.len_zero      = (len_r == '0);
  assign sts.idx_last      = (idx_inc == {1'b0, len_r});
  assign sts.target_valid  = after_v_r || first_v_r;
  assign sts.target_is_cur = present_r && (target == cur_r);
  assign sts.present       = present_r;

  `RRTS_ASSERT_IMP(a_len_bound, clk, rst_n, 1'b1, len_r <= LW'(NSLOT))
  `RRTS_ASSERT_NXT(a_present_sticky, clk, rst_n, present_r, present_r)
  `RRTS_ASSERT_IMP(a_shift_after_hit, clk, rst_n, ram_we && !cmd.append, idx_r != '0)

endmodule
